[design/nrsq_pkg.sv]
`timescale 1ns / 1ps

package nrsq_pkg;

    localparam int PitchInW  = 9;
    localparam int NoteW     = 7;
    localparam int RootW     = 4;
    localparam int ModeW     = 4;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 7;
    localparam int IntervalN = 12;

    localparam logic [NoteW-1:0] NoteMax  = 7'd127;
    localparam logic [NoteW-1:0] VelMin   = 7'd1;

    typedef logic [IntervalN-1:0] t_mask;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_ROOT     = 2'd0,
        REG_SCALE_MODE   = 2'd1,
        REG_LOWEST_NOTE  = 2'd2,
        REG_HIGHEST_NOTE = 2'd3
    } t_reg_idx;

    typedef enum logic [ModeW-1:0] {
        MODE_MAJOR      = 4'd0,
        MODE_MINOR      = 4'd1,
        MODE_DORIAN     = 4'd2,
        MODE_PHRYGIAN   = 4'd3,
        MODE_LYDIAN     = 4'd4,
        MODE_MIXOLYDIAN = 4'd5,
        MODE_LOCRIAN    = 4'd6,
        MODE_PENTATONIC = 4'd7,
        MODE_BLUES      = 4'd8,
        MODE_HARM_MINOR = 4'd9,
        MODE_MEL_MINOR  = 4'd10
    } t_mode;

    // bit i set when interval i belongs to the mode
    function automatic t_mask mode_mask(input logic [ModeW-1:0] mode);
        t_mask m;
        case (t_mode'(mode))
            MODE_MAJOR:      m = 12'hAB5;
            MODE_MINOR:      m = 12'h5AD;
            MODE_DORIAN:     m = 12'h6AD;
            MODE_PHRYGIAN:   m = 12'h5AB;
            MODE_LYDIAN:     m = 12'hAD5;
            MODE_MIXOLYDIAN: m = 12'h6B5;
            MODE_LOCRIAN:    m = 12'h56B;
            MODE_PENTATONIC: m = 12'h295;
            MODE_BLUES:      m = 12'h4E9;
            MODE_HARM_MINOR: m = 12'h9AD;
            MODE_MEL_MINOR:  m = 12'hAAD;
            default:         m = 12'hAB5;
        endcase
        return m;
    endfunction

    // x mod 12 for x below 128: quotient by reciprocal 171/2048
    function automatic logic [3:0] mod12(input logic [NoteW-1:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [NoteW-1:0] r;
        prod = 15'(x) * 15'd171;
        q    = prod[14:11];
        r    = x - NoteW'(q) * NoteW'(12);
        return r[3:0];
    endfunction

    // candidate n (may be out of 0..127) is in the scale starting at root
    function automatic logic is_member(input logic signed [PitchInW-1:0] n,
                                       input logic [RootW-1:0] root,
                                       input t_mask mask);
        logic [NoteW-1:0] off;
        logic ok;
        ok  = (n >= $signed({5'd0, root})) && (n <= $signed({2'd0, NoteMax}));
        off = n[NoteW-1:0] - NoteW'(root);
        return ok && mask[mod12(off)];
    endfunction

endpackage

[design/note_range_scale_quantizer_top.sv]
`timescale 1ns / 1ps

// Quantizes one note per cycle: the pitch is clamped to lowest_note, then to
// highest_note, and snapped to the nearest note of the selected scale (lower
// note on a tie); velocity is clamped to 1..127. An item is taken at any edge
// with start high and busy low; its result shows on o_done after the input
// register and then the result register, so one item every cycle. busy is
// set in reset and cleared by the clock once reset is released. The receiver
// cannot stall: o_done lasts exactly one cycle; the results hold until the next.
// Register writes must come only while no item is in flight.
module note_range_scale_quantizer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [nrsq_pkg::PitchInW-1:0] i_pitch_in,
    input  logic signed [nrsq_pkg::PitchInW-1:0] i_velocity_in,
    output logic                              o_done,
    output logic [nrsq_pkg::NoteW-1:0]        o_pitch_out,
    output logic [nrsq_pkg::NoteW-1:0]        o_velocity_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nrsq_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [nrsq_pkg::CfgDataW-1:0]     i_cfg_data
);

    localparam int PW = nrsq_pkg::PitchInW;
    localparam int NW = nrsq_pkg::NoteW;

    logic                 r_busy;
    logic [nrsq_pkg::RootW-1:0] r_key_root;
    logic [nrsq_pkg::ModeW-1:0] r_scale_mode;
    logic [NW-1:0]        r_lowest_note;
    logic [NW-1:0]        r_highest_note;

    logic                 r_in_vld;
    logic signed [PW-1:0] r_pitch;
    logic signed [PW-1:0] r_vel;

    logic                 r_done;
    logic [NW-1:0]        r_pitch_out;
    logic [NW-1:0]        r_vel_out;

    logic                 accept;
    logic                 cfg_wr;
    logic signed [PW-1:0] p_lo;
    logic [NW-1:0]        p_clamp;
    logic signed [PW-1:0] p_s;
    nrsq_pkg::t_mask      mask;
    logic [NW-1:0]        n_pitch_out;
    logic [NW-1:0]        n_vel_out;

    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_root     <= '0;
            r_scale_mode   <= '0;
            r_lowest_note  <= '0;
            r_highest_note <= nrsq_pkg::NoteMax;
        end else if (cfg_wr) begin
            case (nrsq_pkg::t_reg_idx'(i_cfg_index))
                nrsq_pkg::REG_KEY_ROOT:     r_key_root     <= i_cfg_data[nrsq_pkg::RootW-1:0];
                nrsq_pkg::REG_SCALE_MODE:   r_scale_mode   <= i_cfg_data[nrsq_pkg::ModeW-1:0];
                nrsq_pkg::REG_LOWEST_NOTE:  r_lowest_note  <= i_cfg_data[NW-1:0];
                nrsq_pkg::REG_HIGHEST_NOTE: r_highest_note <= i_cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pitch <= i_pitch_in;
            r_vel   <= i_velocity_in;
        end
    end

    // lower bound first, upper bound wins when they cross
    always_comb begin
        p_lo    = (r_pitch < $signed({2'd0, r_lowest_note}))
                  ? $signed({2'd0, r_lowest_note}) : r_pitch;
        p_clamp = (p_lo > $signed({2'd0, r_highest_note}))
                  ? r_highest_note : p_lo[NW-1:0];
        p_s     = $signed({2'd0, p_clamp});
        mask    = nrsq_pkg::mode_mask(r_scale_mode);
    end

    // scale gaps are at most three, so the nearest member lies within two;
    // candidates are checked nearest first, lower first on equal distance
    always_comb begin
        if (p_clamp <= NW'(r_key_root)) begin
            n_pitch_out = NW'(r_key_root);
        end else if (nrsq_pkg::is_member(p_s, r_key_root, mask)) begin
            n_pitch_out = p_clamp;
        end else if (nrsq_pkg::is_member(p_s - PW'(1), r_key_root, mask)) begin
            n_pitch_out = p_clamp - NW'(1);
        end else if (nrsq_pkg::is_member(p_s + PW'(1), r_key_root, mask)) begin
            n_pitch_out = p_clamp + NW'(1);
        end else if (nrsq_pkg::is_member(p_s - PW'(2), r_key_root, mask)) begin
            n_pitch_out = p_clamp - NW'(2);
        end else if (nrsq_pkg::is_member(p_s + PW'(2), r_key_root, mask)) begin
            n_pitch_out = p_clamp + NW'(2);
        end else begin
            n_pitch_out = p_clamp;
        end
    end

    always_comb begin
        if (r_vel < $signed({2'd0, nrsq_pkg::VelMin})) begin
            n_vel_out = nrsq_pkg::VelMin;
        end else if (r_vel > $signed({2'd0, nrsq_pkg::NoteMax})) begin
            n_vel_out = nrsq_pkg::NoteMax;
        end else begin
            n_vel_out = r_vel[NW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_pitch_out <= n_pitch_out;
            r_vel_out   <= n_vel_out;
        end
    end

    assign o_done         = r_done;
    assign o_pitch_out    = r_pitch_out;
    assign o_velocity_out = r_vel_out;

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 2))
        else $error("result without a transfer two cycles earlier");

    a_accept_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("accepted item produced no result");

    a_vel_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_velocity_out != '0))
        else $error("velocity out of range");

    a_pitch_above_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pitch_out >= NW'(r_key_root)))
        else $error("pitch below scale root");

endmodule
